FILE: hdl/apic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apic_pkg;

  // section codes carried with every result
  localparam logic [3:0] SEC_HEADER   = 4'd0;
  localparam logic [3:0] SEC_ENCODING = 4'd1;
  localparam logic [3:0] SEC_MIME     = 4'd2;
  localparam logic [3:0] SEC_MIME_END = 4'd3;
  localparam logic [3:0] SEC_TYPE     = 4'd4;
  localparam logic [3:0] SEC_DESC     = 4'd5;
  localparam logic [3:0] SEC_DESC_END = 4'd6;
  localparam logic [3:0] SEC_PICTURE  = 4'd7;
  localparam logic [3:0] SEC_DISCARD  = 4'd8;

  // status codes reported on the last result of a frame
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [2:0] ST_NO_MIME_END  = 3'd2;
  localparam logic [2:0] ST_MIME_BAD     = 3'd3;
  localparam logic [2:0] ST_NO_TYPE      = 3'd4;
  localparam logic [2:0] ST_NO_DESC_END  = 3'd5;

  localparam logic [3:0] HEADER_BYTES_RESET = 4'd10;
  localparam logic [7:0] KIND_MAX           = 8'd20;
  localparam int         MIME_COUNT         = 4;

  // allowed mime strings, left aligned in 10 characters
  localparam logic [79:0] MIME_PNG        = {"png", 56'd0};
  localparam logic [79:0] MIME_JPEG       = {"jpeg", 48'd0};
  localparam logic [79:0] MIME_IMAGE_PNG  = {"image/png", 8'd0};
  localparam logic [79:0] MIME_IMAGE_JPEG = "image/jpeg";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] section;
    logic [4:0] picture_kind;
    logic       wide_text;
    logic       last_result;
    logic [2:0] status;
  } result_t;

  // length of an allowed mime string
  function automatic logic [3:0] mime_len(input logic [1:0] c);
    logic [3:0] len;
    unique case (c)
      2'd0:    len = 4'd3;
      2'd1:    len = 4'd4;
      2'd2:    len = 4'd9;
      default: len = 4'd10;
    endcase
    return len;
  endfunction

  // character at a position of an allowed mime string, zero past the end
  function automatic logic [7:0] mime_char(input logic [1:0] c, input logic [3:0] idx);
    logic [79:0] str;
    logic [6:0]  pos;
    unique case (c)
      2'd0:    str = MIME_PNG;
      2'd1:    str = MIME_JPEG;
      2'd2:    str = MIME_IMAGE_PNG;
      default: str = MIME_IMAGE_JPEG;
    endcase
    if (idx > 4'd9) begin
      return 8'd0;
    end
    pos = 7'd79 - {idx, 3'b000};
    return str[pos -: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/attached_picture_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Attached-picture frame parser: tags each frame byte with its section and
// reports frame status on the final result. One byte is taken per cycle and
// its first result can leave on the cycle after it is taken. A held wide zero
// yields nothing on its own and two results when its partner arrives. The
// three-entry output queue takes a byte whenever at most one result remains
// after the current output transaction, so with a consumer that is always
// ready a byte is taken every cycle; the input only waits while the consumer
// stalls and results back up. The user must write header_bytes through the
// cfg channel only while no frame is in flight; the block does not enforce it.
module attached_picture_frame_parser
  import apic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire byte_item_t byte_item,
  output logic            result_valid,
  input  wire logic       result_ready,
  output result_t         result_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);

  logic       accept;
  logic [1:0] push_count;
  result_t    first;
  result_t    second;

  assign cfg_ready = 1'b1;
  assign accept    = byte_valid && byte_ready;

  // per-byte classification and frame state
  apic_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .item       (byte_item),
    .push_count (push_count),
    .first      (first),
    .second     (second)
  );

  // result queue toward the consumer
  apic_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .first      (first),
    .second     (second),
    .room       (byte_ready),
    .valid      (result_valid),
    .ready      (result_ready),
    .head       (result_item)
  );

endmodule

`default_nettype wire

FILE: hdl/apic_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module apic_classify
  import apic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [3:0] cfg_data,
  input  wire logic       accept,
  input  wire byte_item_t item,
  output logic [1:0]      push_count,
  output result_t         first,
  output result_t         second
);

  logic [3:0] header_bytes;
  logic [3:0] current_section;
  logic [3:0] header_count;
  logic [3:0] mime_length;
  logic [3:0] mime_match;
  logic       wide_flag;
  logic       pair_phase;
  logic       pending_zero;
  logic [2:0] error_code;
  logic [4:0] kind_held;

  logic [3:0] current_section_next;
  logic [3:0] header_count_next;
  logic [3:0] mime_length_next;
  logic [3:0] mime_match_next;
  logic       wide_flag_next;
  logic       pair_phase_next;
  logic       pending_zero_next;
  logic [2:0] error_code_next;
  logic [4:0] kind_held_next;

  logic [7:0] b;
  logic       mime_ok;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [3:0] sec0;
  logic [3:0] sec1;
  logic [2:0] st;
  logic [1:0] n;

  assign b = item.data_byte;

  // terminated mime text equals one of the allowed strings
  always_comb begin
    mime_ok = 1'b0;
    for (int c = 0; c < MIME_COUNT; c++) begin
      if (mime_match[c] && mime_len(2'(c)) == mime_length) begin
        mime_ok = 1'b1;
      end
    end
  end

  // section walk for one byte
  always_comb begin
    current_section_next = current_section;
    header_count_next    = header_count;
    mime_length_next     = mime_length;
    mime_match_next      = mime_match;
    wide_flag_next       = wide_flag;
    pair_phase_next      = pair_phase;
    pending_zero_next    = pending_zero;
    error_code_next      = error_code;
    kind_held_next       = kind_held;
    byte0 = b;
    byte1 = b;
    sec0  = SEC_DISCARD;
    sec1  = SEC_DISCARD;
    st    = ST_OK;
    n     = 2'd1;
    unique case (current_section)
      SEC_HEADER: begin
        if (header_count < header_bytes) begin
          header_count_next = header_count + 4'd1;
          sec0 = SEC_HEADER;
          st   = ST_TOO_SHORT;
        end else begin
          wide_flag_next       = (b == 8'd1) || (b == 8'd2);
          sec0                 = SEC_ENCODING;
          current_section_next = SEC_MIME;
          st                   = ST_NO_MIME_END;
        end
      end
      SEC_MIME: begin
        if (b != 8'd0) begin
          for (int c = 0; c < MIME_COUNT; c++) begin
            if (mime_length >= mime_len(2'(c)) || mime_char(2'(c), mime_length) != b) begin
              mime_match_next[c] = 1'b0;
            end
          end
          if (mime_length != 4'd15) begin
            mime_length_next = mime_length + 4'd1;
          end
          sec0 = SEC_MIME;
          st   = ST_NO_MIME_END;
        end else begin
          sec0 = SEC_MIME_END;
          if (mime_ok) begin
            current_section_next = SEC_TYPE;
            st = ST_NO_TYPE;
          end else begin
            error_code_next      = ST_MIME_BAD;
            current_section_next = SEC_DISCARD;
            st = ST_MIME_BAD;
          end
        end
      end
      SEC_TYPE: begin
        kind_held_next       = (b >= 8'd1 && b <= KIND_MAX) ? b[4:0] : 5'd0;
        sec0                 = SEC_TYPE;
        current_section_next = SEC_DESC;
        pair_phase_next      = 1'b0;
        pending_zero_next    = 1'b0;
        st                   = ST_NO_DESC_END;
      end
      SEC_DESC: begin
        st = ST_NO_DESC_END;
        if (!wide_flag) begin
          if (b == 8'd0) begin
            sec0 = SEC_DESC_END;
            current_section_next = SEC_PICTURE;
            st = ST_OK;
          end else begin
            sec0 = SEC_DESC;
          end
        end else if (!pair_phase) begin
          pair_phase_next = 1'b1;
          if (b == 8'd0 && !item.frame_end) begin
            // hold the zero until its partner shows up
            pending_zero_next = 1'b1;
            n = 2'd0;
          end else begin
            sec0 = SEC_DESC;
          end
        end else begin
          pair_phase_next = 1'b0;
          if (pending_zero) begin
            byte0 = 8'd0;
            pending_zero_next = 1'b0;
            n = 2'd2;
            if (b == 8'd0) begin
              sec0 = SEC_DESC_END;
              sec1 = SEC_DESC_END;
              current_section_next = SEC_PICTURE;
              st = ST_OK;
            end else begin
              sec0 = SEC_DESC;
              sec1 = SEC_DESC;
            end
          end else begin
            sec0 = SEC_DESC;
          end
        end
      end
      SEC_PICTURE: begin
        sec0 = SEC_PICTURE;
        st   = ST_OK;
      end
      default: begin
        sec0 = SEC_DISCARD;
        st   = error_code;
      end
    endcase
  end

  // result fields, tagged last and status at frame end
  always_comb begin
    first.byte_out     = byte0;
    first.section      = sec0;
    first.picture_kind = kind_held_next;
    first.wide_text    = wide_flag_next;
    first.last_result  = 1'b0;
    first.status       = ST_OK;
    second.byte_out     = byte1;
    second.section      = sec1;
    second.picture_kind = kind_held_next;
    second.wide_text    = wide_flag_next;
    second.last_result  = 1'b0;
    second.status       = ST_OK;
    if (item.frame_end) begin
      if (n == 2'd2) begin
        second.last_result = 1'b1;
        second.status      = st;
      end else begin
        first.last_result = 1'b1;
        first.status      = st;
      end
    end
  end

  assign push_count = accept ? n : 2'd0;

  // frame state and header length register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes    <= HEADER_BYTES_RESET;
      current_section <= SEC_HEADER;
      header_count    <= 4'd0;
      mime_length     <= 4'd0;
      mime_match      <= 4'hF;
      wide_flag       <= 1'b0;
      pair_phase      <= 1'b0;
      pending_zero    <= 1'b0;
      error_code      <= ST_OK;
      kind_held       <= 5'd0;
    end else begin
      if (cfg_write) begin
        header_bytes <= cfg_data;
      end
      if (accept) begin
        if (item.frame_end) begin
          current_section <= SEC_HEADER;
          header_count    <= 4'd0;
          mime_length     <= 4'd0;
          mime_match      <= 4'hF;
          wide_flag       <= 1'b0;
          pair_phase      <= 1'b0;
          pending_zero    <= 1'b0;
          error_code      <= ST_OK;
          kind_held       <= 5'd0;
        end else begin
          current_section <= current_section_next;
          header_count    <= header_count_next;
          mime_length     <= mime_length_next;
          mime_match      <= mime_match_next;
          wide_flag       <= wide_flag_next;
          pair_phase      <= pair_phase_next;
          pending_zero    <= pending_zero_next;
          error_code      <= error_code_next;
          kind_held       <= kind_held_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/apic_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module apic_out_queue
  import apic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_count,
  input  wire result_t    first,
  input  wire result_t    second,
  output logic            room,
  output logic            valid,
  input  wire logic       ready,
  output result_t         head
);

  result_t    q [3];
  result_t    q_next [3];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] base;
  logic       pop;

  assign valid = (count != 2'd0);
  assign pop   = valid && ready;
  assign head  = q[0];
  // room for two results once the head transaction leaves
  assign room  = (base < 2'd2);

  // shift out the head, append new results behind what remains
  always_comb begin
    q_next = q;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    base = count - {1'b0, pop};
    if (push_count != 2'd0) begin
      q_next[base] = first;
    end
    if (push_count == 2'd2) begin
      q_next[base + 2'd1] = second;
    end
    count_next = base + push_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import apic_pkg::*;

  localparam int PHASES         = 6;
  localparam int RANDOM_BYTES   = 650;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;
  // slowest legal gap: the longest byte-side idle gap plus two results each
  // at the longest stall, plus the drain pause; taken many times over
  localparam int QUIET_LIMIT    = 500;

  // text encoding byte values
  localparam logic [7:0] ENC_LATIN1  = 8'd0;
  localparam logic [7:0] ENC_UTF16   = 8'd1;
  localparam logic [7:0] ENC_UTF16BE = 8'd2;
  localparam logic [7:0] ENC_UTF8    = 8'd3;
  localparam logic [7:0] KIND_TOP    = 8'd20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  attached_picture_frame_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // stimulus and expectation stores
  byte_item_t pending_bytes[$];
  logic [7:0] frame_buf[$];
  result_t    expected_tags[$];
  int         queued_count = 0;
  int         taken_count = 0;
  int         mismatch_count = 0;
  int         byte_gap_max = 0;
  int         res_stall_max = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  bit         byte_acc = 1'b0;
  bit         res_acc = 1'b0;

  // parser state as the testbench tracks it
  logic [3:0] header_limit = HEADER_BYTES_RESET;
  logic [3:0] cur_section;
  logic [3:0] hdr_seen;
  logic [3:0] mime_len_seen;
  logic [3:0] mime_hits;
  logic       wide_mode;
  logic       odd_half;
  logic       zero_held;
  logic [2:0] frame_error;
  logic [4:0] kind_now;

  // accepted mime strings, left aligned
  function automatic logic [79:0] allowed_mime(input int c);
    case (c)
      0:       return {"png", 56'd0};
      1:       return {"jpeg", 48'd0};
      2:       return {"image/png", 8'd0};
      default: return "image/jpeg";
    endcase
  endfunction

  function automatic int mime_chars(input int c);
    logic [79:0] txt;
    int          n;
    txt = allowed_mime(c);
    n = 0;
    while (n < 10 && txt[79 - 8 * n -: 8] != 8'd0) n++;
    return n;
  endfunction

  function automatic result_t make_tag(input logic [7:0] b, input logic [3:0] sec);
    result_t t;
    t = '0;
    t.byte_out = b;
    t.section = sec;
    t.picture_kind = kind_now;
    t.wide_text = wide_mode;
    return t;
  endfunction

  task automatic clear_frame_state();
    cur_section = SEC_HEADER;
    hdr_seen = 4'd0;
    mime_len_seen = 4'd0;
    mime_hits = 4'hF;
    wide_mode = 1'b0;
    odd_half = 1'b0;
    zero_held = 1'b0;
    frame_error = ST_OK;
    kind_now = 5'd0;
  endtask

  // classify one accepted byte and queue the tags it produces
  task automatic tag_frame_byte(input logic [7:0] b, input logic last);
    result_t     tags[$];
    result_t     fin;
    logic [2:0]  st;
    logic [3:0]  sec;
    logic [79:0] txt;
    logic        ok;
    st = ST_OK;
    case (cur_section)
      SEC_HEADER: begin
        if (hdr_seen < header_limit) begin
          hdr_seen = hdr_seen + 4'd1;
          tags = {tags, make_tag(b, SEC_HEADER)};
          st = ST_TOO_SHORT;
        end else begin
          wide_mode = (b == ENC_UTF16 || b == ENC_UTF16BE);
          tags = {tags, make_tag(b, SEC_ENCODING)};
          cur_section = SEC_MIME;
          st = ST_NO_MIME_END;
        end
      end
      SEC_MIME: begin
        if (b != 8'd0) begin
          for (int c = 0; c < MIME_COUNT; c++) begin
            txt = allowed_mime(c);
            if (int'(mime_len_seen) >= mime_chars(c)) begin
              mime_hits[c] = 1'b0;
            end else if (txt[79 - 8 * int'(mime_len_seen) -: 8] != b) begin
              mime_hits[c] = 1'b0;
            end
          end
          if (mime_len_seen != 4'd15) mime_len_seen = mime_len_seen + 4'd1;
          tags = {tags, make_tag(b, SEC_MIME)};
          st = ST_NO_MIME_END;
        end else begin
          tags = {tags, make_tag(b, SEC_MIME_END)};
          ok = 1'b0;
          for (int c = 0; c < MIME_COUNT; c++) begin
            if (mime_hits[c] && mime_chars(c) == int'(mime_len_seen)) ok = 1'b1;
          end
          if (ok) begin
            cur_section = SEC_TYPE;
            st = ST_NO_TYPE;
          end else begin
            frame_error = ST_MIME_BAD;
            cur_section = SEC_DISCARD;
            st = ST_MIME_BAD;
          end
        end
      end
      SEC_TYPE: begin
        kind_now = (b >= 8'd1 && b <= KIND_TOP) ? b[4:0] : 5'd0;
        tags = {tags, make_tag(b, SEC_TYPE)};
        cur_section = SEC_DESC;
        odd_half = 1'b0;
        zero_held = 1'b0;
        st = ST_NO_DESC_END;
      end
      SEC_DESC: begin
        st = ST_NO_DESC_END;
        if (!wide_mode) begin
          if (b == 8'd0) begin
            tags = {tags, make_tag(b, SEC_DESC_END)};
            cur_section = SEC_PICTURE;
            st = ST_OK;
          end else begin
            tags = {tags, make_tag(b, SEC_DESC)};
          end
        end else if (!odd_half) begin
          // a zero on the first half of a unit waits for its partner
          if (b == 8'd0 && !last) begin
            zero_held = 1'b1;
          end else begin
            tags = {tags, make_tag(b, SEC_DESC)};
          end
          odd_half = 1'b1;
        end else begin
          if (zero_held) begin
            sec = (b == 8'd0) ? SEC_DESC_END : SEC_DESC;
            tags = {tags, make_tag(8'd0, sec)};
            tags = {tags, make_tag(b, sec)};
            zero_held = 1'b0;
            if (b == 8'd0) begin
              cur_section = SEC_PICTURE;
              st = ST_OK;
            end
          end else begin
            tags = {tags, make_tag(b, SEC_DESC)};
          end
          odd_half = 1'b0;
        end
      end
      SEC_PICTURE: begin
        tags = {tags, make_tag(b, SEC_PICTURE)};
        st = ST_OK;
      end
      default: begin
        tags = {tags, make_tag(b, SEC_DISCARD)};
        st = frame_error;
      end
    endcase
    if (last && tags.size() > 0) begin
      fin = tags.pop_back();
      fin.last_result = 1'b1;
      fin.status = st;
      tags = {tags, fin};
      clear_frame_state();
    end
    expected_tags = {expected_tags, tags};
  endtask

  // frame building
  task automatic append_mime(input int c);
    logic [79:0] txt;
    txt = allowed_mime(c);
    for (int i = 0; i < mime_chars(c); i++) frame_buf = {frame_buf, txt[79 - 8 * i -: 8]};
  endtask

  task automatic send_frame();
    byte_item_t item;
    foreach (frame_buf[i]) begin
      item.data_byte = frame_buf[i];
      item.frame_end = (i == frame_buf.size() - 1);
      pending_bytes = {pending_bytes, item};
    end
    queued_count += frame_buf.size();
    frame_buf.delete();
  endtask

  task automatic queue_frame();
    int         enc;
    int         pick;
    int         c;
    int         cut;
    logic [7:0] lo;
    logic [7:0] hi;
    if ($urandom_range(0, 9) == 0) begin
      // noise frame
      repeat ($urandom_range(1, 20)) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    end else begin
      repeat (header_limit) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      enc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                        : $urandom_range(ENC_LATIN1, ENC_UTF8);
      frame_buf = {frame_buf, 8'(enc)};
      // mime text: mostly allowed, else near misses and junk
      pick = $urandom_range(0, 9);
      c = $urandom_range(0, MIME_COUNT - 1);
      if (pick < 9) append_mime(c);
      if (pick == 6) frame_buf = {frame_buf, 8'($urandom_range(1, 255))};
      if (pick == 7) lo = frame_buf.pop_back();
      if (pick == 8) begin
        lo = frame_buf.pop_back();
        frame_buf = {frame_buf, lo ^ 8'h20};
      end
      if (pick == 9) begin
        repeat ($urandom_range(0, 20)) frame_buf = {frame_buf, 8'($urandom_range(1, 255))};
      end
      frame_buf = {frame_buf, 8'd0};
      // picture type
      if ($urandom_range(0, 3) != 0) frame_buf = {frame_buf, 8'($urandom_range(1, 20))};
      else frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      // description
      if (enc == int'(ENC_UTF16) || enc == int'(ENC_UTF16BE)) begin
        repeat ($urandom_range(0, 4)) begin
          lo = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          hi = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          if (lo == 8'd0 && hi == 8'd0) hi = 8'($urandom_range(1, 255));
          frame_buf = {frame_buf, lo};
          frame_buf = {frame_buf, hi};
        end
        frame_buf = {frame_buf, 8'd0};
      end else begin
        repeat ($urandom_range(0, 5)) frame_buf = {frame_buf, 8'($urandom_range(1, 255))};
      end
      frame_buf = {frame_buf, 8'd0};
      // picture data
      repeat ($urandom_range(0, 8)) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
      // truncated frame
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > cut) lo = frame_buf.pop_back();
      end
    end
    send_frame();
  endtask

  // byte driver: one transaction per pending item, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left = 0;
    end else if (!byte_valid || byte_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        byte_item <= pending_bytes.pop_front();
        byte_valid <= 1'b1;
        gap_left = $urandom_range(0, byte_gap_max);
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result sink: random stall after each transaction
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_acc) stall_left = $urandom_range(0, res_stall_max);
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on byte transactions, check result transactions
  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (rst) begin
      byte_acc = 1'b0;
      res_acc = 1'b0;
      header_limit = HEADER_BYTES_RESET;
      clear_frame_state();
    end else begin
      byte_acc = byte_valid && byte_ready;
      res_acc = result_valid && result_ready;
      if (byte_acc) begin
        taken_count++;
        tag_frame_byte(byte_item.data_byte, byte_item.frame_end);
      end
      if (res_acc) begin
        if (expected_tags.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("unexpected result: byte %h sec %0d kind %0d wide %b last %b st %0d",
                     result_item.byte_out, result_item.section, result_item.picture_kind,
                     result_item.wide_text, result_item.last_result, result_item.status);
          end
          mismatch_count++;
        end else begin
          want = expected_tags.pop_front();
          bad = (result_item.byte_out !== want.byte_out) ||
                (result_item.section !== want.section) ||
                (result_item.picture_kind !== want.picture_kind) ||
                (result_item.wide_text !== want.wide_text) ||
                (result_item.last_result !== want.last_result) ||
                (result_item.status !== want.status);
          if (bad) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("mismatch: want byte %h sec %0d kind %0d wide %b last %b st %0d",
                       want.byte_out, want.section, want.picture_kind,
                       want.wide_text, want.last_result, want.status);
              $display("          got  byte %h sec %0d kind %0d wide %b last %b st %0d",
                       result_item.byte_out, result_item.section, result_item.picture_kind,
                       result_item.wide_text, result_item.last_result, result_item.status);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // register write, entered and left at a falling edge
  task automatic write_header_bytes(input logic [3:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    header_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every byte is taken and every tag has come back
  task automatic wait_drained();
    do @(negedge clk); while (taken_count != queued_count || expected_tags.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // test sequence
  initial begin
    int setting;
    int target;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames with no header bytes
    write_header_bytes(4'd0);
    @(posedge clk);
    // narrow text, out-of-range type
    frame_buf = {frame_buf, ENC_LATIN1};
    append_mime(0);
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, 8'hFF};
    frame_buf = {frame_buf, 8'h80};
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, 8'hFF};
    send_frame();
    // wide text with a held zero, ending on the terminator pair
    frame_buf = {frame_buf, ENC_UTF16};
    append_mime(1);
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, KIND_TOP};
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, 8'h41};
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, 8'd0};
    send_frame();
    // lone wide zero as the last byte
    frame_buf = {frame_buf, ENC_UTF16BE};
    append_mime(0);
    frame_buf = {frame_buf, 8'd0};
    frame_buf = {frame_buf, 8'd1};
    frame_buf = {frame_buf, 8'd0};
    send_frame();
    wait_drained();

    // random phases over several header sizes and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       setting = 15;
        1:       setting = 0;
        2:       setting = 1;
        default: setting = $urandom_range(0, 15);
      endcase
      write_header_bytes(4'(setting));
      byte_gap_max = (p == 1 || p == 3) ? 0 : 10;
      res_stall_max = (p == 1 || p == 2) ? 0 : 10;
      @(posedge clk);
      target = queued_count + RANDOM_BYTES / PHASES;
      while (queued_count < target) queue_frame();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
